FILE: sv/bhwm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and payload types for the best Hamming window match block.
package bhwm_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int LANES       = 16;
   localparam int MAX_TEXT    = 65536;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 5;
   localparam int LANE_IDX_W = $clog2(LANES);
   localparam int COUNT_W    = $clog2(MAX_TEXT + 1);
   localparam int START_W    = 16;
   localparam int WORD_W     = 64;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_PATTERN_LEN  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              last;
   } req_payload_type;

   typedef struct packed {
      logic               found;
      logic [LEN_W-1:0]   best_score;
      logic [START_W-1:0] best_start;
      logic [WORD_W-1:0]  window_bytes_low;
      logic [WORD_W-1:0]  window_bytes_high;
      logic               too_long;
   } rsp_payload_type;

   // Bookkeeping that follows one item from the cell row into the tracker.
   typedef struct packed {
      logic               valid;
      logic               last;
      logic               eligible;
      logic [START_W-1:0] start;
      logic               overflow;
   } stage_type;

endpackage

FILE: sv/bhwm_cell.sv
`timescale 1ns / 1ps
// One cell of the window row: holds a text byte and its match against a pattern byte.
module bhwm_cell
   import bhwm_pkg::*;
(
   input  logic              clock,
   input  logic              shift_en,
   input  logic [BYTE_W-1:0] byte_in,
   input  logic [BYTE_W-1:0] pattern_byte,
   input  logic              lane_en,
   output logic [BYTE_W-1:0] byte_out,
   output logic              match_out
);

   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;
   logic              match_ff;
   logic              match_in;

   // The match is taken against the byte that enters, so it lines up with data_ff.
   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      if (shift_en) begin
         data_in  = byte_in;
         match_in = lane_en && (byte_in == pattern_byte);
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign byte_out  = data_ff;
   assign match_out = match_ff;

endmodule

FILE: sv/bhwm_tracker.sv
`timescale 1ns / 1ps
// Scores each window, keeps the best one of the text and forms the result.
module bhwm_tracker
   import bhwm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  stage_type               stage,
   input  logic                    advance,
   input  logic [LANES-1:0]        match,
   input  logic [LANES*BYTE_W-1:0] window,
   output rsp_payload_type         result
);

   logic [LEN_W-1:0]        score;
   logic                    take;
   logic [LEN_W-1:0]        top_score_ff;
   logic [LEN_W-1:0]        top_score_in;
   logic [START_W-1:0]      top_start_ff;
   logic [START_W-1:0]      top_start_in;
   logic [LANES*BYTE_W-1:0] top_window_ff;
   logic [LANES*BYTE_W-1:0] top_window_in;
   logic [LEN_W-1:0]        new_score;
   logic [START_W-1:0]      new_start;
   logic [LANES*BYTE_W-1:0] new_window;

   assign score = LEN_W'($countones(match));
   assign take  = stage.valid && stage.eligible && (score > top_score_ff);

   // Best values including the window now in this stage.
   always_comb begin
      new_score  = top_score_ff;
      new_start  = top_start_ff;
      new_window = top_window_ff;
      if (take) begin
         new_score  = score;
         new_start  = stage.start;
         new_window = window;
      end
   end

   always_comb begin
      top_score_in  = top_score_ff;
      top_start_in  = top_start_ff;
      top_window_in = top_window_ff;
      if (advance && stage.valid) begin
         if (stage.last) begin
            top_score_in  = '0;
            top_start_in  = '0;
            top_window_in = '0;
         end else begin
            top_score_in  = new_score;
            top_start_in  = new_start;
            top_window_in = new_window;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_score_ff  <= '0;
         top_start_ff  <= '0;
         top_window_ff <= '0;
      end else begin
         top_score_ff  <= top_score_in;
         top_start_ff  <= top_start_in;
         top_window_ff <= top_window_in;
      end
   end

   always_comb begin
      result          = '0;
      result.too_long = stage.overflow;
      if (new_score != '0) begin
         result.found             = 1'b1;
         result.best_score        = new_score;
         result.best_start        = new_start;
         result.window_bytes_low  = new_window[WORD_W-1:0];
         result.window_bytes_high = new_window[2*WORD_W-1:WORD_W];
      end
   end

endmodule

FILE: sv/best_hamming_window_match_top.sv
`timescale 1ns / 1ps
// Top level of the streaming best Hamming window match search.
//
// The block takes one text byte per clock cycle and scores every window of
// pattern_length consecutive bytes against the configured pattern, keeping the
// first window with the strictly highest number of equal positions. Bytes pass
// along a row of sixteen cells, each holding one recent byte and comparing the
// byte it takes in against the pattern byte of its window position, so all
// positions are compared in parallel. A second stage counts the matches and
// updates the best window. The result for a text moves from the second stage
// into the output register that drives the rsp channel. The sustained rate is
// one item per cycle; after a last item the block holds req_ready low only while
// an earlier result still waits in the output register and rsp_ready is low. Bytes
// beyond 65536 in one text are not scored and set too_long. Configuration
// registers are to be written through the csr port only while the block is idle,
// which the block itself does not enforce; they keep their values across texts.
module best_hamming_window_match_top
   import bhwm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   // Configuration registers.
   logic [WORD_W-1:0] pattern_low_ff;
   logic [WORD_W-1:0] pattern_high_ff;
   logic [LEN_W-1:0]  pattern_len_ff;
   logic [WORD_W-1:0] pattern_low_in;
   logic [WORD_W-1:0] pattern_high_in;
   logic [LEN_W-1:0]  pattern_len_in;

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      pattern_len_in  = pattern_len_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pattern_low_in  = csr_wdata;
            CSR_PATTERN_HIGH: pattern_high_in = csr_wdata;
            CSR_PATTERN_LEN:  pattern_len_in  = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         pattern_len_ff  <= LEN_W'(1);
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         pattern_len_ff  <= pattern_len_in;
      end
   end

   // Window length in use: zero counts as one, anything above the maximum is clamped.
   logic [LEN_W-1:0] win_len;

   always_comb begin
      win_len = pattern_len_ff;
      if (pattern_len_ff == '0) begin
         win_len = LEN_W'(1);
      end else if (pattern_len_ff > LEN_W'(MAX_PATTERN)) begin
         win_len = LEN_W'(MAX_PATTERN);
      end
   end

   logic [LANES*BYTE_W-1:0] pattern_all;
   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   // Handshake and stage control.
   stage_type          stage_ff;
   stage_type          stage_in;
   logic               advance;
   logic               req_accept;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_payload_type    rsp_data_ff;
   rsp_payload_type    rsp_data_in;
   rsp_payload_type    result;

   // The second stage holds a last item only while the output register is full and rsp_ready is low.
   assign advance    = !(stage_ff.valid && stage_ff.last && rsp_valid_ff && !rsp_ready);
   assign req_ready  = advance;
   assign req_accept = req_valid && req_ready;

   // Per-text byte count and overflow flag.
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_next;
   logic               overflow_ff;
   logic               overflow_in;
   logic               has_room;
   logic               shift_en;

   assign has_room   = count_ff < COUNT_W'(MAX_TEXT);
   assign shift_en   = req_accept && has_room;
   assign count_next = count_ff + COUNT_W'(1);

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (req_accept) begin
         if (req_data.last) begin
            count_in    = '0;
            overflow_in = 1'b0;
         end else if (has_room) begin
            count_in = count_next;
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_comb begin
      stage_in = stage_ff;
      if (advance) begin
         stage_in.valid    = req_accept;
         stage_in.last     = req_data.last;
         stage_in.eligible = has_room && (count_next >= COUNT_W'(win_len));
         stage_in.start    = START_W'(count_next - COUNT_W'(win_len));
         stage_in.overflow = overflow_ff || !has_room;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         stage_ff    <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         stage_ff    <= stage_in;
      end
   end

   // Row of cells; the newest byte enters at the highest cell and moves down.
   logic [BYTE_W-1:0] cell_byte [LANES];
   logic [LANES-1:0]  cell_match;

   for (genvar i = 0; i < LANES; i++) begin : g_cell
      logic [BYTE_W-1:0] byte_in;
      logic [LEN_W-1:0]  pos_sum;
      logic [BYTE_W-1:0] pat_byte;
      logic              lane_en;

      // Cell i holds window position i + len - LANES when that is not negative.
      assign pos_sum  = LEN_W'(i) + win_len;
      assign lane_en  = pos_sum >= LEN_W'(LANES);
      assign pat_byte = pattern_all[pos_sum[LANE_IDX_W-1:0]*BYTE_W +: BYTE_W];

      if (i == LANES - 1) begin : g_head
         assign byte_in = req_data.text_byte;
      end else begin : g_link
         assign byte_in = cell_byte[i+1];
      end

      bhwm_cell u_cell (
         .clock        (clock),
         .shift_en     (shift_en),
         .byte_in      (byte_in),
         .pattern_byte (pat_byte),
         .lane_en      (lane_en),
         .byte_out     (cell_byte[i]),
         .match_out    (cell_match[i])
      );
   end

   // Current window realigned so its first byte sits in lane zero, unused lanes zero.
   logic [LANES*BYTE_W-1:0] window;

   always_comb begin
      logic [LEN_W-1:0] src;
      window = '0;
      for (int k = 0; k < LANES; k++) begin
         src = LEN_W'(k) - win_len;
         if (LEN_W'(k) < win_len) begin
            window[k*BYTE_W +: BYTE_W] = cell_byte[src[LANE_IDX_W-1:0]];
         end
      end
   end

   bhwm_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage_ff),
      .advance (advance),
      .match   (cell_match),
      .window  (window),
      .result  (result)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && stage_ff.valid && stage_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: dv/best_hamming_window_match_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming best Hamming window match block.
module best_hamming_window_match_top_test;
   import bhwm_pkg::*;

   // Index 3 fits the csr_index port but names no register; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   // Cycles allowed after the last result for the two-stage pipeline to empty.
   localparam int SETTLE_CYCLES = 6;
   // Long receiver hold used to back the block up into its input.
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int BURST_TEXTS = 40;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int CLOSING_ITEMS = 40;
   // The long text runs a few bytes past capacity, and the last of them carries the last mark.
   localparam int LONG_TEXT_BYTES = MAX_TEXT + 4;
   localparam int PLANTED_START = 65500;
   localparam int PHASE_COUNT = 10;
   // Window lengths of the random phases. Zero must act as one, and 17 and 31 must act as 16.
   localparam logic [LEN_W-1:0] PHASE_LENGTHS [PHASE_COUNT] =
      '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd5, 5'd8, 5'd12, 5'd3};

   // Tracks the search state of one text and queues the report that each last item produces.
   class window_match_tracker;
      logic [WORD_W-1:0] pattern_low;
      logic [WORD_W-1:0] pattern_high;
      logic [LEN_W-1:0]  pattern_len;
      logic [BYTE_W-1:0] recent[LANES];
      logic [BYTE_W-1:0] best_window[LANES];
      int unsigned       byte_count;
      int unsigned       best_score;
      int unsigned       best_start;
      bit                overflow_seen;
      rsp_payload_type   pending_reports[$];
      int unsigned       error_count;

      function new();
         pattern_low  = '0;
         pattern_high = '0;
         pattern_len  = 5'd1;
         error_count  = 0;
         clear_text();
      endfunction

      function void clear_text();
         foreach (recent[k]) recent[k] = '0;
         foreach (best_window[k]) best_window[k] = '0;
         byte_count    = 0;
         best_score    = 0;
         best_start    = 0;
         overflow_seen = 1'b0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [WORD_W-1:0] value);
         case (index)
            CSR_PATTERN_LOW:  pattern_low  = value;
            CSR_PATTERN_HIGH: pattern_high = value;
            CSR_PATTERN_LEN:  pattern_len  = value[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // The register keeps its raw five bits; the window uses them clamped to 1..16.
      function int unsigned window_length();
         if (pattern_len == 0) return 1;
         if (pattern_len > MAX_PATTERN) return MAX_PATTERN;
         return pattern_len;
      endfunction

      function logic [BYTE_W-1:0] pattern_at(int unsigned k);
         if (k < 8) return pattern_low[k*8 +: 8];
         return pattern_high[(k-8)*8 +: 8];
      endfunction

      function int unsigned pending();
         return pending_reports.size();
      endfunction

      function void shift_in(logic [BYTE_W-1:0] value);
         int unsigned span;
         int unsigned base;
         int unsigned score;
         for (int k = 0; k < LANES - 1; k++) recent[k] = recent[k+1];
         recent[LANES-1] = value;
         byte_count++;
         span = window_length();
         if (byte_count < span) return;
         base  = LANES - span;
         score = 0;
         for (int unsigned k = 0; k < span; k++)
            if (recent[base+k] == pattern_at(k)) score++;
         // Only a strictly better window replaces the kept one, so ties keep the earliest.
         if (score > best_score) begin
            best_score = score;
            best_start = byte_count - span;
            foreach (best_window[k]) best_window[k] = (k < span) ? recent[base+k] : 8'h00;
         end
      endfunction

      function void take_text_byte(req_payload_type item);
         rsp_payload_type report;
         if (byte_count < MAX_TEXT) shift_in(item.text_byte);
         else overflow_seen = 1'b1;
         if (!item.last) return;
         report = '0;
         if (best_score > 0) begin
            report.found      = 1'b1;
            report.best_score = LEN_W'(best_score);
            report.best_start = START_W'(best_start);
            for (int k = 0; k < 8; k++) begin
               report.window_bytes_low[k*8 +: 8]  = best_window[k];
               report.window_bytes_high[k*8 +: 8] = best_window[k+8];
            end
         end
         report.too_long = overflow_seen;
         pending_reports.push_back(report);
         clear_text();
      endfunction

      function void compare_report_field(string name, logic [WORD_W-1:0] want,
                                         logic [WORD_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
         end
      endfunction

      function void check_report(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_reports.size() == 0) begin
            $display("%0t: report with no text outstanding, expected none, actual %h",
                     $time, got);
            error_count++;
            return;
         end
         want = pending_reports.pop_front();
         compare_report_field("found", want.found, got.found);
         compare_report_field("best_score", want.best_score, got.best_score);
         compare_report_field("best_start", want.best_start, got.best_start);
         compare_report_field("window_bytes_low", want.window_bytes_low, got.window_bytes_low);
         compare_report_field("window_bytes_high", want.window_bytes_high,
                              got.window_bytes_high);
         compare_report_field("too_long", want.too_long, got.too_long);
      endfunction
   endclass

   // Every input of the block holds a known value from time zero.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PATTERN_LOW;
   logic [WORD_W-1:0]    csr_wdata = '0;

   window_match_tracker  match_tracker;
   // Set for the closing part of the run, where neither side idles.
   bit                   quiet_mode = 1'b0;
   // Raised by the sender to ask the receiver for one long hold.
   bit                   stall_rsp_request = 1'b0;
   int unsigned          items_sent = 0;
   logic [BYTE_W-1:0]    directed_bytes[$];

   best_hamming_window_match_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs or drops a report.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // Receiver. Reports are checked at the edge where they are taken. Between reports the
   // receiver sometimes stalls for a short burst, and it honors one long hold on request.
   // All handshake signals are sampled right after the edge, so they still hold their
   // values from before it.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) match_tracker.check_report(rsp_data);
         if (stall_rsp_request) begin
            stall_rsp_request <= 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one item and returns at the edge where it is taken. Valid is lowered only
   // before an idle burst, so back-to-back items keep it high without a glitch.
   task automatic send_item(input req_payload_type item);
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      match_tracker.take_text_byte(item);
      items_sent++;
   endtask

   // Stops offering, waits for every outstanding report, then lets the pipeline empty.
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (match_tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers plus the unused index. Only called while the block is idle.
   task automatic program_pattern(input logic [WORD_W-1:0] low, input logic [WORD_W-1:0] high,
                                  input logic [LEN_W-1:0] len);
      logic [WORD_W-1:0] len_word;
      logic [WORD_W-1:0] spare_word;
      // Upper bits of the length write are noise; the register keeps only its low five bits.
      len_word   = {$urandom, $urandom};
      len_word[LEN_W-1:0] = len;
      spare_word = {$urandom, $urandom};
      settle_idle();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PATTERN_LOW;
      csr_wdata    <= low;
      @(posedge clock);
      csr_index <= CSR_PATTERN_HIGH;
      csr_wdata <= high;
      @(posedge clock);
      csr_index <= CSR_PATTERN_LEN;
      csr_wdata <= len_word;
      @(posedge clock);
      csr_index <= CSR_SPARE_INDEX;
      csr_wdata <= spare_word;
      @(posedge clock);
      csr_write_en <= 1'b0;
      match_tracker.set_register(CSR_PATTERN_LOW, low);
      match_tracker.set_register(CSR_PATTERN_HIGH, high);
      match_tracker.set_register(CSR_PATTERN_LEN, len_word);
      match_tracker.set_register(CSR_SPARE_INDEX, spare_word);
   endtask

   // Sends directed_bytes in order, marking the final one as last when close is set.
   task automatic send_directed(input bit close);
      req_payload_type item;
      foreach (directed_bytes[i]) begin
         item.text_byte = directed_bytes[i];
         item.last      = close && (i == directed_bytes.size() - 1);
         send_item(item);
      end
   endtask

   // Random text built mostly from pattern bytes. Some runs are in pattern order, so that
   // windows often score high. Random bytes in between act as noise and break up matches.
   task automatic send_text(input int unsigned count);
      req_payload_type item;
      int unsigned     span;
      int unsigned     phase;
      span  = match_tracker.window_length();
      phase = $urandom_range(0, 15);
      for (int unsigned i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: item.text_byte = match_tracker.pattern_at((i + phase) % span);
            4, 5, 6:    item.text_byte = 8'($urandom_range(0, 255));
            default:    item.text_byte = match_tracker.pattern_at($urandom_range(0, span - 1));
         endcase
         item.last = (i == count - 1);
         send_item(item);
      end
   endtask

   // Usually at least as long as the window, now and then no longer than it, so that at most one window exists.
   task automatic send_random_text();
      int unsigned span;
      span = match_tracker.window_length();
      if ($urandom_range(0, 5) == 0) send_text($urandom_range(1, span));
      else send_text($urandom_range(span, 3 * span + 4));
   endtask

   initial begin
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] high;
      int unsigned       phase_end;
      req_payload_type   item;

      match_tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed texts under the reset pattern: a zero pattern byte with length one.
      // The first text matches, and the second has no matching window at all.
      directed_bytes = '{8'h00};
      send_directed(1'b1);
      directed_bytes = '{8'hFF};
      send_directed(1'b1);

      // Pattern AA BB CC with a pattern_high of all ones that a length of three never reads.
      program_pattern(64'h0000_0000_00CC_BBAA, '1, 5'd3);
      // A text shorter than the window reports nothing found.
      directed_bytes = '{8'hAA};
      send_directed(1'b1);
      // A partial match first, then a perfect one later in the text.
      directed_bytes = '{8'h11, 8'hBB, 8'h22, 8'hAA, 8'hBB, 8'hCC};
      send_directed(1'b1);
      // Two windows tie on score, and the earlier one must be kept.
      directed_bytes = '{8'hAA, 8'h00, 8'h00, 8'hAA, 8'h00, 8'h00};
      send_directed(1'b1);

      // The pattern changes halfway through a text, before any window is complete. The bytes
      // already taken stay in the row, and every window is scored against the new pattern.
      directed_bytes = '{8'hAA, 8'hBB};
      send_directed(1'b0);
      program_pattern(64'h0000_0000_0033_2211, '0, 5'd3);
      directed_bytes = '{8'h33, 8'h11, 8'h22, 8'h33};
      send_directed(1'b1);

      // A zero pattern length behaves as a length of one.
      program_pattern(64'h0000_0000_0000_00FF, '0, 5'd0);
      directed_bytes = '{8'hFF};
      send_directed(1'b1);

      // Random phases. Each one sets a pattern and a length, then streams random texts.
      // The first two phases use the all-zero and all-ones patterns.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin
               low  = '0;
               high = '0;
            end
            1: begin
               low  = '1;
               high = '1;
            end
            default: begin
               low  = {$urandom, $urandom};
               high = {$urandom, $urandom};
            end
         endcase
         program_pattern(low, high, PHASE_LENGTHS[p]);
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) send_random_text();
      end

      // Back-pressure: the receiver holds off for a long stretch while one-byte texts keep
      // coming. The output register fills up, and the block has to stall its input.
      settle_idle();
      stall_rsp_request <= 1'b1;
      for (int i = 0; i < BURST_TEXTS; i++) send_text(1);

      // Closing part, with no idling on either side. First comes a text that runs past
      // capacity. A perfect window is planted near the end of the counted range, so
      // best_start uses its upper bits. The bytes beyond capacity are dropped, and the
      // report must show too_long.
      quiet_mode = 1'b1;
      program_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'd8);
      for (int i = 0; i < LONG_TEXT_BYTES; i++) begin
         if (i >= PLANTED_START && i < PLANTED_START + 8)
            item.text_byte = match_tracker.pattern_at(i - PLANTED_START);
         else
            item.text_byte = 8'($urandom_range(0, 255));
         item.last = (i == LONG_TEXT_BYTES - 1);
         send_item(item);
      end
      // Then a few full-width windows.
      program_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
      phase_end = items_sent + CLOSING_ITEMS;
      while (items_sent < phase_end) send_random_text();

      // Wait for every report, then keep watching for anything extra while the pipeline empties.
      settle_idle();
      if (match_tracker.error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
